// File: rtl/uad_pkg.sv
// ----------------------------------------------------------------------------
// uad_pkg - shared types and constants for the unsigned-to-ASCII digit block
// Mode codes, controller states, status struct and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package uad_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int MAX_DIGITS_DEF  = 16;
  localparam int CMD_W           = 2;
  localparam int CHAR_W          = 7;
  localparam int DEC_BITS_MAX    = 32;

  localparam logic [CMD_W-1:0] CMD_DEC       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEX_LOWER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HEX_UPPER = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  // trunc: the number needs more than MAX_DIGITS digits
  typedef struct packed {
    logic busy;
    logic upper;
    logic trunc;
  } conv_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d,
                                                       input logic       upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (d <= 4'd9) begin
      digit_to_ascii = ASCII_ZERO + {3'b000, d};
    end else begin
      digit_to_ascii = base + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

// File: rtl/uad_conv.sv
// ----------------------------------------------------------------------------
// uad_conv - digit converter
// Hex: nibbles load straight into the digit register. Decimal: shift-and-add-3, one bit a cycle,
// into a BCD register of MAX_DIGITS digits (overflow digits drop off the top).
// ----------------------------------------------------------------------------
module uad_conv #(
  parameter int VALUE_WIDTH = uad_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = uad_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [uad_pkg::CMD_W-1:0]   cmd,
  input  logic [VALUE_WIDTH-1:0]      value,
  output uad_pkg::conv_stat_t         stat,
  output logic [4*MAX_DIGITS-1:0]     digits
);

  localparam int DEC_BITS = (VALUE_WIDTH < uad_pkg::DEC_BITS_MAX) ?
                            VALUE_WIDTH : uad_pkg::DEC_BITS_MAX;
  localparam int DIG_W    = 4 * MAX_DIGITS;
  localparam int CNT_W    = $clog2(DEC_BITS + 1);

  logic [DEC_BITS-1:0]          src;
  logic [CNT_W-1:0]             bits_left;
  logic                         upper;
  logic                         trunc;
  logic                         hex;
  logic [DIG_W+VALUE_WIDTH-1:0] ext;
  logic [DIG_W-1:0]             adj;
  logic [DIG_W-1:0]             dabble_next;

  assign hex = (cmd != uad_pkg::CMD_DEC);
  assign ext = {{DIG_W{1'b0}}, value};

  // add 3 to every BCD digit of five or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? (digits[4*i +: 4] + 4'd3)
                                                  : digits[4*i +: 4];
    end
    dabble_next = {adj[DIG_W-2:0], src[DEC_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
    end else if (load) begin
      bits_left <= hex ? '0 : CNT_W'(DEC_BITS);
    end else if (bits_left != '0) begin
      bits_left <= bits_left - 1'b1;
    end
  end

  // flag any digit that falls off the top so the emitter keeps leading zeros
  always_ff @(posedge clk) begin
    if (load) begin
      upper <= cmd[1];
      src   <= value[DEC_BITS-1:0];
      if (hex) begin
        digits <= ext[DIG_W-1:0];
        trunc  <= (ext[DIG_W +: VALUE_WIDTH] != '0);
      end else begin
        digits <= '0;
        trunc  <= 1'b0;
      end
    end else if (bits_left != '0) begin
      digits <= dabble_next;
      src    <= {src[DEC_BITS-2:0], 1'b0};
      trunc  <= trunc | adj[DIG_W-1];
    end
  end

  assign stat.busy  = (bits_left != '0);
  assign stat.upper = upper;
  assign stat.trunc = trunc;

endmodule

// File: rtl/uad_emit.sv
// ----------------------------------------------------------------------------
// uad_emit - digit emitter
// Shifts the digit register out from the top, one digit a cycle unless the
// output stalls, dropping leading zeros unless the number was cut to
// MAX_DIGITS digits, and holds each word in an output register.
// ----------------------------------------------------------------------------
module uad_emit #(
  parameter int MAX_DIGITS = uad_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [4*MAX_DIGITS-1:0]     digits,
  input  logic                        upper,
  input  logic                        trunc,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [uad_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last
);

  localparam int DIG_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [DIG_W-1:0] dig;
  logic [CNT_W-1:0] cnt;
  logic             found;
  logic             upper_q;
  logic [3:0]       top;
  logic             active;
  logic             skip;
  logic             slot_free;
  logic             emit;

  assign top       = dig[DIG_W-1 -: 4];
  assign active    = (cnt != '0);
  assign skip      = active && !found && (top == 4'd0) && (cnt != CNT_W'(1));
  assign slot_free = !out_valid || !out_stall;
  assign emit      = active && !skip && slot_free;
  assign busy      = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt   <= CNT_W'(MAX_DIGITS);
        found <= trunc;
      end else begin
        if (skip || emit) begin
          cnt <= cnt - 1'b1;
        end
        if (active && !skip) begin
          found <= 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig     <= digits;
      upper_q <= upper;
    end else if (skip || emit) begin
      dig <= {dig[DIG_W-5:0], 4'b0000};
    end
    if (emit) begin
      digit_char <= uad_pkg::digit_to_ascii(top, upper_q);
      last       <= (cnt == CNT_W'(1));
    end
  end

endmodule

// File: rtl/unsigned_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits - unsigned number to ASCII decimal or hex digits
// Converts one number per input word and emits its digits, most significant
// first, one output word per digit, the final one flagged by last.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_stall  cmd, value
//   out      out_valid/ out_stall digit_char, last
//
// Steps per number: accept, conversion (min(VALUE_WIDTH,32) bit steps for
// decimal, none for hex), handoff, MAX_DIGITS emitter steps (leading zeros
// dropped one a cycle, digits sent one a cycle), back to idle.
// out_stall stretches the emitter steps; in_stall stays high from acceptance
// until the cycle after the final digit enters the output register.
// rst is synchronous and clears the controller, counters and output valid.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits #(
  parameter int VALUE_WIDTH = uad_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = uad_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [uad_pkg::CMD_W-1:0]   cmd,
  input  logic [VALUE_WIDTH-1:0]      value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [uad_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last
);

  uad_pkg::state_t     state;
  uad_pkg::state_t     state_next;
  uad_pkg::conv_stat_t conv_stat;
  logic [4*MAX_DIGITS-1:0] digits;
  logic accept;
  logic emit_load;
  logic emit_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      uad_pkg::ST_IDLE: if (in_valid) state_next = uad_pkg::ST_CONV;
      uad_pkg::ST_CONV: if (!conv_stat.busy) state_next = uad_pkg::ST_EMIT;
      uad_pkg::ST_EMIT: if (!emit_busy) state_next = uad_pkg::ST_IDLE;
      default:          state_next = uad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != uad_pkg::ST_IDLE);
    accept    = in_valid && !in_stall;
    emit_load = (state == uad_pkg::ST_CONV) && !conv_stat.busy;
  end

  uad_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_conv (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .cmd    (cmd),
    .value  (value),
    .stat   (conv_stat),
    .digits (digits)
  );

  uad_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (emit_load),
    .digits     (digits),
    .upper      (conv_stat.upper),
    .trunc      (conv_stat.trunc),
    .busy       (emit_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule

// File: rtl/uad_check.sv
// ----------------------------------------------------------------------------
// uad_check - port-level checks for unsigned_to_ascii_digits
// Watches both channels and flags words or stalls that break the design.
// ----------------------------------------------------------------------------
module uad_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [uad_pkg::CHAR_W-1:0]  digit_char,
  input logic                        last
);

  // a stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(last))
    else $error("stalled output word changed");

  // every word is a decimal or hex digit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= 7'd48 && digit_char <= 7'd57) ||
                  (digit_char >= 7'd97 && digit_char <= 7'd102) ||
                  (digit_char >= 7'd65 && digit_char <= 7'd70))
    else $error("output word is not a digit");

  // one number at a time: input closes right after acceptance
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open after acceptance");

  // no new number while a digit other than the final one is shown
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input open in the middle of a number");

endmodule

bind unsigned_to_ascii_digits uad_check u_uad_check (.*);

// File: sim/uad_digit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uad_digit_checker - scoreboard for the unsigned-to-ASCII digit block
// Watches both channels. Each accepted number is turned into its expected
// digit words, which are queued and compared field by field with the
// digit words that the block delivers.
// ----------------------------------------------------------------------------
module uad_digit_checker #(
  parameter int VALUE_WIDTH = uad_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = uad_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [uad_pkg::CMD_W-1:0]    cmd,
  input  logic [VALUE_WIDTH-1:0]       value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [uad_pkg::CHAR_W-1:0]   digit_char,
  input  logic                         last,
  output int                           mismatches,
  output int                           pending,
  output int                           digits_checked
);

  typedef struct packed {
    logic [uad_pkg::CHAR_W-1:0] ch;
    logic                       tail;
  } digit_word_t;

  digit_word_t expected_digits[$];
  int          mismatch_count = 0;
  int          checked_count  = 0;

  assign mismatches     = mismatch_count;
  assign digits_checked = checked_count;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns  digit mismatch: %s", $time, what);
  endtask

  // Split one number into digits, least significant first, then queue them
  // most significant first; only the lowest MAX_DIGITS digits survive.
  function automatic void queue_number_digits(
    input logic [uad_pkg::CMD_W-1:0] mode,
    input logic [VALUE_WIDTH-1:0]    number
  );
    logic [63:0]                rest;
    logic [63:0]                radix;
    logic [3:0]                 digs[MAX_DIGITS];
    logic [uad_pkg::CHAR_W-1:0] letter_a;
    logic                       hex_mode;
    digit_word_t                w;
    int                         n;
    hex_mode = (mode != uad_pkg::CMD_DEC);
    letter_a = mode[1] ? uad_pkg::ASCII_UPPER_A : uad_pkg::ASCII_LOWER_A;
    radix    = hex_mode ? 64'd16 : 64'd10;
    rest     = 64'(number);
    if (!hex_mode) begin
      rest = {32'b0, rest[31:0]};
    end
    n = 0;
    do begin
      digs[n] = 4'(rest % radix);
      rest    = rest / radix;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      if (digs[k] <= 4'd9) begin
        w.ch = uad_pkg::ASCII_ZERO + uad_pkg::CHAR_W'(digs[k]);
      end else begin
        w.ch = letter_a + uad_pkg::CHAR_W'(digs[k]) - uad_pkg::CHAR_W'(10);
      end
      w.tail = (k == 0);
      expected_digits.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    digit_word_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        queue_number_digits(cmd, value);
      end
      if (out_valid && !out_stall) begin
        checked_count++;
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("char %0d last %0b arrived with nothing expected",
                                    digit_char, last));
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch) begin
            report_mismatch($sformatf("char %0d, expected %0d", digit_char, want.ch));
          end
          if (last !== want.tail) begin
            report_mismatch($sformatf("last %0b, expected %0b", last, want.tail));
          end
        end
      end
      pending <= expected_digits.size();
    end
  end

endmodule

// File: sim/tb_unsigned_to_ascii_digits.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unsigned_to_ascii_digits - testbench for the unsigned-to-ASCII digit block
// Feeds directed corner numbers in every mode, then random numbers of random
// magnitude, with random gaps on the sender and random stalls on the
// receiver, plus long receiver hold-offs. A checker module predicts and
// compares every digit word.
// ----------------------------------------------------------------------------
module tb_unsigned_to_ascii_digits;

  // unused code, acts as upper hex
  localparam logic [uad_pkg::CMD_W-1:0] CMD_HEX_ALT = 2'd3;

  localparam int RANDOM_NUMBERS = 348;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 64;
  localparam int CYCLE_LIMIT    = 1000000;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic [uad_pkg::CMD_W-1:0]           cmd;
  logic [uad_pkg::VALUE_WIDTH_DEF-1:0] value;
  logic                                out_valid;
  logic                                out_stall;
  logic [uad_pkg::CHAR_W-1:0]          digit_char;
  logic                                last;

  int mismatches;
  int pending;
  int digits_checked;
  int cycle_count = 0;
  int send_burst  = 0;
  int mode_count[4] = '{0, 0, 0, 0};

  unsigned_to_ascii_digits i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

  uad_digit_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digit_char     (digit_char),
    .last           (last),
    .mismatches     (mismatches),
    .pending        (pending),
    .digits_checked (digits_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digit words outstanding",
               cycle_count, pending);
      $display("unsigned_to_ascii_digits test failed");
      $finish;
    end
  end

  // Offer one number after a random gap; return at the edge that takes it.
  task automatic offer_number(input logic [uad_pkg::CMD_W-1:0] mode,
                              input logic [63:0]               number);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      send_burst = $urandom_range(8, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= mode;
    value    <= number;
    do @(posedge clk); while (in_stall);
    mode_count[mode]++;
  endtask

  // Receiver: random stall before each word, bursts without stalls, and
  // long hold-offs so the block backs up into its input.
  initial begin
    int gap;
    int burst;
    int words;
    burst = 0;
    words = 0;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (words == 40 || words == 2500) begin
        gap = LONG_HOLD;
      end else if (burst > 0) begin
        burst--;
        gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        burst = $urandom_range(10, 40);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      words++;
    end
  end

  initial begin
    logic [uad_pkg::CMD_W-1:0] mode;
    logic [63:0]               number;
    int                        pick;
    int                        shift;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    cmd      <= uad_pkg::CMD_DEC;
    value    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // decimal: zero, one digit, boundaries, high half ignored
    offer_number(uad_pkg::CMD_DEC, 64'd0);
    offer_number(uad_pkg::CMD_DEC, 64'd9);
    offer_number(uad_pkg::CMD_DEC, 64'd10);
    offer_number(uad_pkg::CMD_DEC, 64'd999999999);
    offer_number(uad_pkg::CMD_DEC, 64'd1000000000);
    offer_number(uad_pkg::CMD_DEC, 64'h0000_0000_FFFF_FFFF);
    offer_number(uad_pkg::CMD_DEC, 64'hFFFF_FFFF_0000_0000);
    offer_number(uad_pkg::CMD_DEC, 64'hDEAD_BEEF_0000_0001);
    offer_number(uad_pkg::CMD_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
    // hex lower case
    offer_number(uad_pkg::CMD_HEX_LOWER, 64'd0);
    offer_number(uad_pkg::CMD_HEX_LOWER, 64'hF);
    offer_number(uad_pkg::CMD_HEX_LOWER, 64'h10);
    offer_number(uad_pkg::CMD_HEX_LOWER, 64'h0123_4567_89AB_CDEF);
    offer_number(uad_pkg::CMD_HEX_LOWER, 64'h8000_0000_0000_0000);
    offer_number(uad_pkg::CMD_HEX_LOWER, 64'hFFFF_FFFF_FFFF_FFFF);
    // hex upper case
    offer_number(uad_pkg::CMD_HEX_UPPER, 64'hA);
    offer_number(uad_pkg::CMD_HEX_UPPER, 64'hFEDC_BA98_7654_3210);
    offer_number(uad_pkg::CMD_HEX_UPPER, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_number(uad_pkg::CMD_HEX_UPPER, 64'd0);
    // unused mode code behaves as upper-case hex
    offer_number(CMD_HEX_ALT, 64'd0);
    offer_number(CMD_HEX_ALT, 64'hAB_CDEF);
    offer_number(CMD_HEX_ALT, 64'hFFFF_FFFF_FFFF_FFFF);

    // random numbers of random magnitude in every mode
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      pick = $urandom_range(0, 15);
      if (pick <= 5) begin
        mode = uad_pkg::CMD_DEC;
      end else if (pick <= 10) begin
        mode = uad_pkg::CMD_HEX_LOWER;
      end else if (pick <= 14) begin
        mode = uad_pkg::CMD_HEX_UPPER;
      end else begin
        mode = CMD_HEX_ALT;
      end
      number = {$urandom(), $urandom()};
      shift  = $urandom_range(0, 64);
      number = (shift == 64) ? 64'd0 : (number >> shift);
      offer_number(mode, number);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("numbers converted: %0d decimal, %0d lower hex, %0d upper hex, %0d unused-code hex",
             mode_count[uad_pkg::CMD_DEC], mode_count[uad_pkg::CMD_HEX_LOWER],
             mode_count[uad_pkg::CMD_HEX_UPPER], mode_count[CMD_HEX_ALT]);
    $display("digit words checked: %0d, mismatches: %0d, still expected: %0d",
             digits_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("unsigned_to_ascii_digits test passed");
    end else begin
      $display("unsigned_to_ascii_digits test failed");
    end
    $finish;
  end

endmodule
